/* rtl/pcrf_pkg.sv */
// Shared types, constants and defaults of the polynomial chord root finder.
package pcrf_pkg;

  // Default arithmetic width and fraction bits.
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned FracBitsDef  = 16;

  // Configuration register indexes.
  localparam logic [2:0] RegCoefFive  = 3'd0;
  localparam logic [2:0] RegCoefFour  = 3'd1;
  localparam logic [2:0] RegCoefThree = 3'd2;
  localparam logic [2:0] RegCoefTwo   = 3'd3;
  localparam logic [2:0] RegCoefOne   = 3'd4;
  localparam logic [2:0] RegCoefZero  = 3'd5;
  localparam logic [2:0] RegStopTol   = 3'd6;
  localparam logic [2:0] RegMaxIter   = 3'd7;

  // Finish codes of one solve.
  typedef enum logic [1:0] {
    ST_CONVERGED = 2'd0,
    ST_LIMIT     = 2'd1,
    ST_ZERO_DIV  = 2'd2
  } pcrf_status_e;

  // Which polynomial the Horner evaluator works on.
  typedef enum logic [1:0] {
    KIND_P  = 2'd0,
    KIND_D1 = 2'd1,
    KIND_D2 = 2'd2
  } pcrf_kind_e;

  // One interval as received.
  typedef struct packed {
    logic signed [31:0] right_end;
    logic signed [31:0] left_end;
  } pcrf_item_t;

  // Register set seen by the solver.
  typedef struct packed {
    logic signed [31:0] coef_five;
    logic signed [31:0] coef_four;
    logic signed [31:0] coef_three;
    logic signed [31:0] coef_two;
    logic signed [31:0] coef_one;
    logic signed [31:0] coef_zero;
    logic [30:0]        stop_tolerance;
    logic [9:0]         max_iterations;
  } pcrf_cfg_t;

endpackage

/* rtl/pcrf_queue.sv */
// Front end: accepts intervals and holds up to two of them for the solver.
module pcrf_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcrf_pkg::pcrf_item_t in_item_i,
  output logic                out_valid_o,
  input  logic                out_pop_i,
  output pcrf_pkg::pcrf_item_t out_item_o
);
  import pcrf_pkg::*;

  pcrf_item_t  slot_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_pop_i && out_valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= in_item_i;
  end

endmodule

/* rtl/pcrf_div.sv */
// Iterative fixed-point divider: one quotient bit per cycle, saturating result.
module pcrf_div #(
  parameter int unsigned DATA_WIDTH = pcrf_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = pcrf_pkg::FracBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [DATA_WIDTH-1:0] num_i,
  input  logic signed [DATA_WIDTH-1:0] den_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] quo_o
);
  import pcrf_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned N    = DATA_WIDTH + FRAC_BITS;
  localparam int unsigned MAGW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int unsigned CW   = $clog2(N + 1);
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic [MAGW-1:0] m);
    logic [MAGW-1:0] lim;
    begin
      lim = MAGW'($unsigned(SMAX));
      if (!neg) sat_mag = (m > lim) ? SMAX : $signed(m[W-1:0]);
      else sat_mag = (m > lim + MAGW'(1)) ? SMIN_OF() : -$signed(m[W-1:0]);
    end
  endfunction

  // Most negative value at the working width.
  function automatic logic signed [W-1:0] SMIN_OF();
    SMIN_OF = {1'b1, {(W-1){1'b0}}};
  endfunction

  logic            busy_q, neg_q, done_q;
  logic [CW-1:0]   cnt_q;
  logic [W-1:0]    rem_q;
  logic [N-1:0]    nq_q;
  logic [W-1:0]    den_q;
  logic signed [W-1:0] quo_q;
  logic [W-1:0]    num_mag, den_mag;
  logic [W:0]      rem_shift, rem_next;
  logic            quo_bit;
  logic [N-1:0]    nq_next;

  assign num_mag = num_i[W-1] ? W'(-num_i) : W'(num_i);
  assign den_mag = den_i[W-1] ? W'(-den_i) : W'(den_i);

  // One restoring step.
  always_comb begin
    rem_shift = {rem_q, nq_q[N-1]};
    quo_bit   = (rem_shift >= {1'b0, den_q});
    rem_next  = quo_bit ? rem_shift - {1'b0, den_q} : rem_shift;
    nq_next   = {nq_q[N-2:0], quo_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_mag == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CW'(N);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath of the divider.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[W-1] ^ den_i[W-1];
      den_q <= den_mag;
      rem_q <= '0;
      nq_q  <= N'(num_mag) << FRAC_BITS;
      if (den_mag == '0) quo_q <= SMAX;
    end else if (busy_q) begin
      rem_q <= rem_next[W-1:0];
      nq_q  <= nq_next;
      if (cnt_q == CW'(1)) quo_q <= sat_mag(neg_q, MAGW'(nq_next));
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/pcrf_engine.sv */
// Back end: sequencer with a shared multiplier and divider that runs the chord method.
module pcrf_engine #(
  parameter int unsigned DATA_WIDTH = pcrf_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = pcrf_pkg::FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pcrf_pkg::pcrf_cfg_t  cfg_i,
  input  logic                 item_valid_i,
  output logic                 item_pop_o,
  input  pcrf_pkg::pcrf_item_t item_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic signed [31:0]   root_estimate_o,
  output logic [9:0]           iterations_used_o,
  output logic [1:0]           finish_status_o,
  output logic                 fixed_end_is_left_o
);
  import pcrf_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned MAGW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int unsigned WIDE = ((DATA_WIDTH > 32) ? DATA_WIDTH : 32) + 8;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [16:0] {
    S_IDLE    = 17'h00001,
    S_EV_LOAD = 17'h00002,
    S_EV_MUL  = 17'h00004,
    S_EV_ADD  = 17'h00008,
    S_GOT_PA  = 17'h00010,
    S_GOT_D2A = 17'h00020,
    S_GOT_DA  = 17'h00040,
    S_GOT_DB  = 17'h00080,
    S_GOT_FD  = 17'h00100,
    S_GOT_FX  = 17'h00200,
    S_MUL_T   = 17'h00400,
    S_DIV_Q   = 17'h00800,
    S_WAIT_Q  = 17'h01000,
    S_GOT_PN  = 17'h02000,
    S_WAIT_E1 = 17'h04000,
    S_WAIT_E2 = 17'h08000,
    S_FINISH  = 17'h10000
  } state_e;

  // Saturating helpers at the working width.
  function automatic logic signed [W-1:0] clamp_wide(input logic signed [WIDE-1:0] v);
    begin
      if (v > WIDE'(SMAX)) clamp_wide = SMAX;
      else if (v < WIDE'(SMIN)) clamp_wide = SMIN;
      else clamp_wide = W'(v);
    end
  endfunction

  function automatic logic signed [W-1:0] fadd(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    fadd = clamp_wide(WIDE'(a) + WIDE'(b));
  endfunction

  function automatic logic signed [W-1:0] fsub(input logic signed [W-1:0] a,
                                              input logic signed [W-1:0] b);
    fsub = clamp_wide(WIDE'(a) - WIDE'(b));
  endfunction

  function automatic logic signed [W-1:0] fabsw(input logic signed [W-1:0] a);
    fabsw = (a == SMIN) ? SMAX : (a[W-1] ? -a : a);
  endfunction

  function automatic logic signed [W-1:0] from32(input logic signed [31:0] v);
    from32 = clamp_wide(WIDE'(v));
  endfunction

  function automatic logic signed [W-1:0] scale_k(input logic signed [W-1:0] a,
                                                 input logic [6:0] k);
    scale_k = clamp_wide(WIDE'(a) * $signed(WIDE'(k)));
  endfunction

  function automatic logic signed [W-1:0] sat_mag(input logic neg, input logic [MAGW-1:0] m);
    logic [MAGW-1:0] lim;
    begin
      lim = MAGW'($unsigned(SMAX));
      if (!neg) sat_mag = (m > lim) ? SMAX : $signed(m[W-1:0]);
      else sat_mag = (m > lim + MAGW'(1)) ? SMIN : -$signed(m[W-1:0]);
    end
  endfunction

  state_e              state_q, state_d, ret_q, ret_d;
  pcrf_kind_e          kind_q, kind_d;
  logic [2:0]          step_q, step_d;
  logic signed [W-1:0] acc_q, acc_d, prod_q, prod_d, pt_q, pt_d;
  logic signed [W-1:0] a_q, a_d, b_q, b_d, x_q, x_d, d_q, d_d;
  logic signed [W-1:0] pa_q, pa_d, da_q, da_d, m1_q, m1_d, fd_q, fd_d;
  logic signed [W-1:0] fx_q, fx_d, diff_q, diff_d, den_q, den_d;
  logic                left_q, left_d;
  logic [9:0]          k_q, k_d, limit;
  logic                res_valid_q, res_valid_d;
  logic signed [31:0]  res_root_q, res_root_d;
  logic [9:0]          res_used_q, res_used_d, fin_used_q, fin_used_d;
  logic [1:0]          res_status_q, res_status_d, fin_status_q, fin_status_d;
  logic                res_left_q, res_left_d;

  // Shared multiplier and divider hookups.
  logic signed [W-1:0] mul_a, mul_b, mul_res;
  logic [W-1:0]        mag_a, mag_b;
  logic                div_start, div_done;
  logic signed [W-1:0] div_num, div_den, div_quo;

  // Scaled coefficient for the current Horner step.
  logic [2:0]          coef_idx;
  logic signed [31:0]  coef_raw;
  logic [6:0]          coef_k;
  logic [2:0]          last_step;
  logic signed [W-1:0] coef_s;

  // Combinational values used by the iteration.
  logic signed [W-1:0] den_now, xn_now, err_now;
  logic [64:0]         err_u;

  assign limit = (cfg_i.max_iterations == '0) ? 10'd1 : cfg_i.max_iterations;

  // The load step always takes the leading coefficient.
  assign coef_idx = (state_q == S_EV_LOAD) ? 3'd0 : step_q;

  always_comb begin
    unique case (coef_idx)
      3'd0:    coef_raw = cfg_i.coef_five;
      3'd1:    coef_raw = cfg_i.coef_four;
      3'd2:    coef_raw = cfg_i.coef_three;
      3'd3:    coef_raw = cfg_i.coef_two;
      3'd4:    coef_raw = cfg_i.coef_one;
      3'd5:    coef_raw = cfg_i.coef_zero;
      default: coef_raw = '0;
    endcase
    unique case (kind_q)
      KIND_D1: begin
        last_step = 3'd4;
        unique case (coef_idx)
          3'd0:    coef_k = 7'd5;
          3'd1:    coef_k = 7'd4;
          3'd2:    coef_k = 7'd3;
          3'd3:    coef_k = 7'd2;
          default: coef_k = 7'd1;
        endcase
      end
      KIND_D2: begin
        last_step = 3'd3;
        unique case (coef_idx)
          3'd0:    coef_k = 7'd20;
          3'd1:    coef_k = 7'd12;
          3'd2:    coef_k = 7'd6;
          default: coef_k = 7'd2;
        endcase
      end
      default: begin
        last_step = 3'd5;
        coef_k    = 7'd1;
      end
    endcase
    coef_s = scale_k(from32(coef_raw), coef_k);
  end

  // One multiplier, truncated towards zero and saturated.
  always_comb begin
    mul_a   = (state_q == S_MUL_T) ? fx_q : acc_q;
    mul_b   = (state_q == S_MUL_T) ? diff_q : pt_q;
    mag_a   = mul_a[W-1] ? W'(-mul_a) : W'(mul_a);
    mag_b   = mul_b[W-1] ? W'(-mul_b) : W'(mul_b);
    mul_res = sat_mag(mul_a[W-1] ^ mul_b[W-1],
                      (MAGW'(mag_a) * MAGW'(mag_b)) >> FRAC_BITS);
  end

  pcrf_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign den_now = fsub(acc_q, fd_q);
  assign xn_now  = fsub(x_q, div_quo);
  assign err_now = scale_k(div_quo, 7'd100);
  assign err_u   = 65'($unsigned(66'(err_now)));

  // Sequencer.
  always_comb begin
    state_d = state_q;  ret_d = ret_q;  kind_d = kind_q;  step_d = step_q;
    acc_d = acc_q;  prod_d = prod_q;  pt_d = pt_q;  a_d = a_q;  b_d = b_q;
    x_d = x_q;  d_d = d_q;  pa_d = pa_q;  da_d = da_q;  m1_d = m1_q;  fd_d = fd_q;
    fx_d = fx_q;  diff_d = diff_q;  den_d = den_q;  left_d = left_q;  k_d = k_q;
    fin_used_d = fin_used_q;  fin_status_d = fin_status_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_root_d = res_root_q;  res_used_d = res_used_q;
    res_status_d = res_status_q;  res_left_d = res_left_q;
    item_pop_o = 1'b0;
    div_start = 1'b0;  div_num = prod_q;  div_den = den_q;

    unique case (state_q)
      S_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          a_d = from32(item_i.left_end);
          b_d = from32(item_i.right_end);
          k_d = 10'd1;
          kind_d = KIND_P;  pt_d = from32(item_i.left_end);  ret_d = S_GOT_PA;
          state_d = S_EV_LOAD;
        end
      end
      S_EV_LOAD: begin
        acc_d  = coef_s;
        step_d = 3'd1;
        state_d = S_EV_MUL;
      end
      S_EV_MUL: begin
        prod_d  = mul_res;
        state_d = S_EV_ADD;
      end
      S_EV_ADD: begin
        acc_d = fadd(prod_q, coef_s);
        if (step_q == last_step) begin
          state_d = ret_q;
        end else begin
          step_d  = step_q + 3'd1;
          state_d = S_EV_MUL;
        end
      end
      S_GOT_PA: begin
        pa_d = acc_q;
        kind_d = KIND_D2;  pt_d = a_q;  ret_d = S_GOT_D2A;  state_d = S_EV_LOAD;
      end
      S_GOT_D2A: begin
        left_d = (pa_q != '0) && (acc_q != '0) && (pa_q[W-1] == acc_q[W-1]);
        d_d = left_d ? a_q : b_q;
        x_d = left_d ? b_q : a_q;
        kind_d = KIND_D1;  pt_d = a_q;  ret_d = S_GOT_DA;  state_d = S_EV_LOAD;
      end
      S_GOT_DA: begin
        da_d = fabsw(acc_q);
        kind_d = KIND_D1;  pt_d = b_q;  ret_d = S_GOT_DB;  state_d = S_EV_LOAD;
      end
      S_GOT_DB: begin
        m1_d = (da_q < fabsw(acc_q)) ? da_q : fabsw(acc_q);
        kind_d = KIND_P;  pt_d = d_q;  ret_d = S_GOT_FD;  state_d = S_EV_LOAD;
      end
      S_GOT_FD: begin
        fd_d = acc_q;
        kind_d = KIND_P;  pt_d = x_q;  ret_d = S_GOT_FX;  state_d = S_EV_LOAD;
      end
      S_GOT_FX: begin
        // A flat chord ends the solve on the current iterate.
        if (den_now == '0) begin
          fin_status_d = ST_ZERO_DIV;
          fin_used_d   = k_q - 10'd1;
          state_d      = S_FINISH;
        end else begin
          fx_d = acc_q;  den_d = den_now;  diff_d = fsub(x_q, d_q);
          state_d = S_MUL_T;
        end
      end
      S_MUL_T: begin
        prod_d  = mul_res;
        state_d = S_DIV_Q;
      end
      S_DIV_Q: begin
        div_start = 1'b1;
        state_d   = S_WAIT_Q;
      end
      S_WAIT_Q: begin
        if (div_done) begin
          x_d = xn_now;
          kind_d = KIND_P;  pt_d = xn_now;  ret_d = S_GOT_PN;  state_d = S_EV_LOAD;
        end
      end
      S_GOT_PN: begin
        div_start = 1'b1;  div_num = fabsw(acc_q);  div_den = m1_q;
        state_d = S_WAIT_E1;
      end
      S_WAIT_E1: begin
        div_num = div_quo;  div_den = fabsw(x_q);
        if (div_done) begin
          div_start = 1'b1;
          state_d   = S_WAIT_E2;
        end
      end
      S_WAIT_E2: begin
        if (div_done) begin
          if (err_u <= 65'(cfg_i.stop_tolerance)) begin
            fin_status_d = ST_CONVERGED;  fin_used_d = k_q;  state_d = S_FINISH;
          end else if (k_q >= limit) begin
            fin_status_d = ST_LIMIT;  fin_used_d = limit;  state_d = S_FINISH;
          end else begin
            k_d = k_q + 10'd1;
            kind_d = KIND_P;  pt_d = x_q;  ret_d = S_GOT_FX;  state_d = S_EV_LOAD;
          end
        end
      end
      S_FINISH: begin
        // Hand over once the output register is free or being emptied.
        if (!res_valid_q || res_ready_i) begin
          res_valid_d  = 1'b1;
          res_root_d   = 32'(x_q);
          res_used_d   = fin_used_q;
          res_status_d = fin_status_q;
          res_left_d   = left_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;  step_q <= step_d;  acc_q <= acc_d;  prod_q <= prod_d;
    pt_q <= pt_d;  a_q <= a_d;  b_q <= b_d;  x_q <= x_d;  d_q <= d_d;
    pa_q <= pa_d;  da_q <= da_d;  m1_q <= m1_d;  fd_q <= fd_d;  fx_q <= fx_d;
    diff_q <= diff_d;  den_q <= den_d;  left_q <= left_d;  k_q <= k_d;
    fin_used_q <= fin_used_d;  fin_status_q <= fin_status_d;
    res_root_q <= res_root_d;  res_used_q <= res_used_d;
    res_status_q <= res_status_d;  res_left_q <= res_left_d;
  end

  assign res_valid_o         = res_valid_q;
  assign root_estimate_o     = res_root_q;
  assign iterations_used_o   = res_used_q;
  assign finish_status_o     = res_status_q;
  assign fixed_end_is_left_o = res_left_q;

endmodule

/* rtl/polynomial_chord_root_finder.sv */
// Top level of the chord-method root finder for a fifth-degree polynomial.
// Each interval [a,b] received is solved on its own and gives one result. The solve runs
// on one shared multiplier and one bit-serial divider. Up to two further intervals wait
// in the input queue, and a finished result is held in an output register until it
// is taken.
module polynomial_chord_root_finder #(
  parameter int unsigned DATA_WIDTH = pcrf_pkg::DataWidthDef,
  parameter int unsigned FRAC_BITS  = pcrf_pkg::FracBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_end [31:0], right_end [63:32]
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // root_estimate [31:0], iterations_used [41:32], finish_status [43:42],
  // fixed_end_is_left [44], zero [47:45]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);
  import pcrf_pkg::*;

  pcrf_cfg_t  cfg_q;
  pcrf_item_t in_item, q_item;
  logic       q_valid, q_pop;
  logic signed [31:0] root;
  logic [9:0]  used;
  logic [1:0]  status;
  logic        left;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.coef_five      <= 32'sd65536;
      cfg_q.coef_four      <= 32'sd0;
      cfg_q.coef_three     <= -32'sd196608;
      cfg_q.coef_two       <= 32'sd131072;
      cfg_q.coef_one       <= -32'sd65536;
      cfg_q.coef_zero      <= 32'sd327680;
      cfg_q.stop_tolerance <= 31'd3277;
      cfg_q.max_iterations <= 10'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegCoefFive:  cfg_q.coef_five      <= cfg_wdata_i;
        RegCoefFour:  cfg_q.coef_four      <= cfg_wdata_i;
        RegCoefThree: cfg_q.coef_three     <= cfg_wdata_i;
        RegCoefTwo:   cfg_q.coef_two       <= cfg_wdata_i;
        RegCoefOne:   cfg_q.coef_one       <= cfg_wdata_i;
        RegCoefZero:  cfg_q.coef_zero      <= cfg_wdata_i;
        RegStopTol:   cfg_q.stop_tolerance <= cfg_wdata_i[30:0];
        RegMaxIter:   cfg_q.max_iterations <= cfg_wdata_i[9:0];
        default:      cfg_q.coef_zero      <= cfg_q.coef_zero;
      endcase
    end
  end

  assign in_item.left_end  = s_axis_tdata[31:0];
  assign in_item.right_end = s_axis_tdata[63:32];

  pcrf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .out_valid_o (q_valid),
    .out_pop_i   (q_pop),
    .out_item_o  (q_item)
  );

  pcrf_engine #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_engine (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .item_valid_i        (q_valid),
    .item_pop_o          (q_pop),
    .item_i              (q_item),
    .res_valid_o         (m_axis_tvalid),
    .res_ready_i         (m_axis_tready),
    .root_estimate_o     (root),
    .iterations_used_o   (used),
    .finish_status_o     (status),
    .fixed_end_is_left_o (left)
  );

  assign m_axis_tdata = {3'b000, left, status, used, root};

endmodule

/* tb/sv/polynomial_chord_root_finder_test.sv */
// Self-checking testbench for the chord-method polynomial root finder.
`timescale 1ns / 1ps

module polynomial_chord_root_finder_test;
  import pcrf_pkg::*;

  localparam longint SatMax = 64'sd2147483647;
  localparam longint SatMin = -64'sd2147483648;

  // One solve result as carried on the master stream.
  typedef struct {
    logic signed [31:0] root_estimate;
    logic [9:0]         iterations_used;
    pcrf_status_e       finish_status;
    logic               fixed_end_is_left;
  } root_result_t;

  // Scoreboard: keeps its own register copy, solves each accepted interval
  // and compares the block's answers in order.
  class chord_scoreboard;
    longint          coef[6];
    longint unsigned tolerance;
    int unsigned     iter_limit;
    root_result_t    pending_roots[$];
    int              errors;

    function new();
      coef = '{65536, 0, -196608, 131072, -65536, 327680};
      tolerance  = 3277;
      iter_limit = 100;
      errors     = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        RegStopTol: tolerance  = 64'(val[30:0]);
        RegMaxIter: iter_limit = 32'(val[9:0]);
        default:    coef[idx]  = longint'($signed(val));
      endcase
    endfunction

    // Saturating fixed-point helpers at the 32-bit data width.
    function longint clampw(longint v);
      return v > SatMax ? SatMax : (v < SatMin ? SatMin : v);
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint from_mag(bit neg, longint unsigned m);
      if (!neg) return m > SatMax ? SatMax : longint'(m);
      if (m > 64'd2147483648) return SatMin;
      return -longint'(m);
    endfunction

    function longint fmul(longint a, longint b);
      return from_mag((a < 0) != (b < 0), (mag(a) * mag(b)) >> 16);
    endfunction

    function longint fdiv(longint a, longint b);
      if (b == 0) return SatMax;
      return from_mag((a < 0) != (b < 0), (mag(a) << 16) / mag(b));
    endfunction

    function longint fabsw(longint a);
      return from_mag(1'b0, mag(a));
    endfunction

    // Horner evaluation of the polynomial and its two derivatives.
    function longint p_at(longint x);
      longint acc;
      acc = coef[0];
      for (int i = 1; i < 6; i++) acc = clampw(fmul(acc, x) + coef[i]);
      return acc;
    endfunction

    function longint d1_at(longint x);
      longint acc;
      acc = clampw(5 * coef[0]);
      acc = clampw(fmul(acc, x) + clampw(4 * coef[1]));
      acc = clampw(fmul(acc, x) + clampw(3 * coef[2]));
      acc = clampw(fmul(acc, x) + clampw(2 * coef[3]));
      return clampw(fmul(acc, x) + coef[4]);
    endfunction

    function longint d2_at(longint x);
      longint acc;
      acc = clampw(20 * coef[0]);
      acc = clampw(fmul(acc, x) + clampw(12 * coef[1]));
      acc = clampw(fmul(acc, x) + clampw(6 * coef[2]));
      return clampw(fmul(acc, x) + clampw(2 * coef[3]));
    endfunction

    function longint sgn(longint v);
      return v > 0 ? 1 : (v < 0 ? -1 : 0);
    endfunction

    // Solve one accepted interval and queue the expected result.
    function void note_interval(logic signed [31:0] left_end, logic signed [31:0] right_end);
      longint       a, b, d, x, fd, fx, den, xn, err, m1, da, db;
      int unsigned  limit, k;
      bit           left;
      root_result_t r;
      a = left_end;
      b = right_end;
      limit = iter_limit == 0 ? 1 : iter_limit;
      left = sgn(p_at(a)) != 0 && sgn(p_at(a)) == sgn(d2_at(a));
      d = left ? a : b;
      x = left ? b : a;
      da = fabsw(d1_at(a));
      db = fabsw(d1_at(b));
      m1 = da < db ? da : db;
      fd = p_at(d);
      k = 1;
      forever begin
        fx = p_at(x);
        den = clampw(fx - fd);
        if (den == 0) begin
          r.finish_status = ST_ZERO_DIV;
          r.iterations_used = 10'(k - 1);
          break;
        end
        xn = clampw(x - fdiv(fmul(fx, clampw(x - d)), den));
        err = clampw(100 * fdiv(fdiv(fabsw(p_at(xn)), m1), fabsw(xn)));
        x = xn;
        if (longint'(err) <= longint'(tolerance)) begin
          r.finish_status = ST_CONVERGED;
          r.iterations_used = 10'(k);
          break;
        end
        k++;
        if (k > limit) begin
          r.finish_status = ST_LIMIT;
          r.iterations_used = 10'(limit);
          break;
        end
      end
      r.root_estimate = x[31:0];
      r.fixed_end_is_left = left;
      pending_roots.push_back(r);
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(logic [47:0] data);
      root_result_t e;
      if (pending_roots.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, data);
        errors++;
        return;
      end
      e = pending_roots.pop_front();
      if (data[31:0] !== e.root_estimate) begin
        $display("%0t: root_estimate expected %h actual %h", $time, e.root_estimate,
                 data[31:0]);
        errors++;
      end
      if (data[41:32] !== e.iterations_used) begin
        $display("%0t: iterations_used expected %0d actual %0d", $time, e.iterations_used,
                 data[41:32]);
        errors++;
      end
      if (data[43:42] !== e.finish_status) begin
        $display("%0t: finish_status expected %0d actual %0d", $time, e.finish_status,
                 data[43:42]);
        errors++;
      end
      if (data[44] !== e.fixed_end_is_left) begin
        $display("%0t: fixed_end_is_left expected %0d actual %0d", $time,
                 e.fixed_end_is_left, data[44]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [31:0] cfg_wdata_i;

  chord_scoreboard roots = new();
  int burst_left = 0;
  int cycle_count = 0;

  polynomial_chord_root_finder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog for a hung solver.
  initial begin
    #(64'd2_000_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: checks each result transaction and stalls on its own pattern,
  // with long stretches where it is always ready.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) roots.check_result(m_axis_tdata);
    if (cycle_count[10:9] == 2'd0) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= $urandom_range(0, 3) != 0;
    end
  end

  // Write all eight registers, one per clock.
  task automatic write_regs(input logic [31:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= i[2:0];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      roots.set_reg(i[2:0], vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Send one interval transaction; gaps come between bursts.
  task automatic send_interval(input logic [31:0] a, input logic [31:0] b);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    roots.note_interval(a, b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 6);
      gap = $urandom_range(1, 15);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Hold off the sender until every expected result has arrived.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (roots.pending_roots.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near_value();
    return $urandom_range(0, 3) == 0 ? $urandom : 32'($urandom_range(0, 524288)) - 32'd262144;
  endfunction

  function automatic logic [31:0] small_coef();
    return $urandom_range(0, 7) == 0 ? $urandom : 32'($urandom_range(0, 1048576)) - 32'd524288;
  endfunction

  // Main sequence.
  initial begin
    logic [31:0] regs[8];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= RegCoefFive;
    cfg_wdata_i   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Directed intervals on the reset polynomial.
    send_interval(32'h8000_0000, 32'h7fff_ffff);
    send_interval(32'h7fff_ffff, 32'h8000_0000);
    send_interval(32'd0, 32'd0);
    send_interval(32'h0001_0000, 32'h0001_0000);
    send_interval(-32'sd196608, -32'sd65536);
    send_interval(-32'sd163840, -32'sd131072);
    send_interval(-32'sd131072, -32'sd163840);
    send_interval(32'hffff_ffff, 32'd1);
    send_interval(32'hffff_ffff, 32'hffff_ffff);
    send_interval(32'h0004_0000, -32'sd262144);
    drain();

    // Deep limit with a zero tolerance: the longest solves.
    regs = '{32'h0001_0000, 32'd0, 32'hfffd_0000, 32'h0002_0000, 32'hffff_0000,
             32'h0005_0000, 32'd0, 32'd1023};
    write_regs(regs);
    send_interval(-32'sd196608, -32'sd65536);
    send_interval(32'd0, 32'h0002_0000);
    drain();

    // Extreme coefficients, widest tolerance and a zero limit; zero slope at
    // the origin makes the error divisor vanish.
    regs = '{32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'h7fff_ffff, 32'd0, 32'h8000_0000,
             32'hffff_ffff, 32'd0};
    write_regs(regs);
    send_interval(32'd0, 32'h0001_0000);
    send_interval(32'h8000_0000, 32'h7fff_ffff);
    send_interval(-32'sd65536, 32'd0);
    drain();

    regs = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h0000_1000, 32'd1};
    write_regs(regs);
    send_interval(32'd0, 32'h0000_8000);
    send_interval(32'h7fff_ffff, 32'h0001_0000);
    drain();

    // Random register settings with random intervals.
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 6; i++) regs[i] = small_coef();
      regs[6] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20000);
      regs[7] = $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 40);
      regs[7][9:6] = regs[7][9:6] & {4{$urandom_range(0, 4) == 0}};
      write_regs(regs);
      for (int n = 0; n < 14; n++) begin
        send_interval(near_value(), near_value());
        if (ph == 2 && n == 6) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    if (roots.errors == 0 && roots.pending_roots.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* polynomial_chord_root_finder.f */
rtl/pcrf_pkg.sv
rtl/pcrf_queue.sv
rtl/pcrf_div.sv
rtl/pcrf_engine.sv
rtl/polynomial_chord_root_finder.sv
tb/sv/polynomial_chord_root_finder_test.sv
